@@ hw/rtl/vsg_pkg.sv @@
// Shared types and constants for the video sync pulse generator.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package vsg_pkg;

   localparam int COORD_BITS_DEFAULT = 10;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 32;
   localparam int REQ_DATA_BITS      = 8;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] REG_HBLANK_INT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VBLANK_INT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HBLANK     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VBLANK     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOAD       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CONTROL    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PIXEL_DIV  = 3'd6;

   // Register reset values
   localparam logic [31:0] HBLANK_INT_RESET = 32'h031D_0000;
   localparam logic [31:0] VBLANK_INT_RESET = 32'h0015_0104;
   localparam logic [31:0] HBLANK_RESET     = 32'h007E_0345;
   localparam logic [31:0] VBLANK_RESET     = 32'h0015_0104;
   localparam logic [31:0] LOAD_RESET       = 32'h0106_0359;
   localparam logic [31:0] CONTROL_RESET    = 32'h0000_0000;
   localparam logic [1:0]  PIXEL_DIV_RESET  = 2'd2;

   // Field positions inside the 32-bit words
   localparam int HI_FIELD_LSB   = 16;
   localparam int MODE_LSB       = 12;
   localparam int INTERLACE_BIT  = 4;

   typedef enum logic [1:0] {
      HIRQ_ON_LINE = 2'd0,
      HIRQ_MODULO  = 2'd1,
      HIRQ_EVERY   = 2'd2,
      HIRQ_OFF     = 2'd3
   } hirq_mode_type;

   typedef struct packed {
      logic [31:0] hblank_int;
      logic [31:0] vblank_int;
      logic [31:0] hblank;
      logic [31:0] vblank;
      logic [31:0] load;
      logic [31:0] control;
      logic [1:0]  pixel_div;
   } cfg_type;

endpackage

`default_nettype wire

@@ hw/rtl/vsg_regs.sv @@
// Configuration register file of the video sync pulse generator.
// Depends on vsg_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module vsg_regs
   import vsg_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   input  wire logic                      mod_busy,
   output logic                           mod_start,
   output cfg_type                        cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign csr_ready = !mod_busy;
   assign wr        = csr_valid && csr_ready;
   assign mod_start = wr && (csr_index == REG_HBLANK_INT);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index)
            REG_HBLANK_INT: cfg_in.hblank_int = csr_data;
            REG_VBLANK_INT: cfg_in.vblank_int = csr_data;
            REG_HBLANK:     cfg_in.hblank     = csr_data;
            REG_VBLANK:     cfg_in.vblank     = csr_data;
            REG_LOAD:       cfg_in.load       = csr_data;
            REG_CONTROL:    cfg_in.control    = csr_data;
            REG_PIXEL_DIV:  cfg_in.pixel_div  = csr_data[1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hblank_int <= HBLANK_INT_RESET;
         cfg_ff.vblank_int <= VBLANK_INT_RESET;
         cfg_ff.hblank     <= HBLANK_RESET;
         cfg_ff.vblank     <= VBLANK_RESET;
         cfg_ff.load       <= LOAD_RESET;
         cfg_ff.control    <= CONTROL_RESET;
         cfg_ff.pixel_div  <= PIXEL_DIV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/vsg_moddiv.sv @@
// Bit-serial remainder unit: (line + 1) mod compare, one quotient bit per cycle.
// Depends on vsg_pkg for COORD_BITS_DEFAULT.
`default_nettype none

module vsg_moddiv
   import vsg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [COORD_BITS-1:0] line,
   input  wire logic [COORD_BITS-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [COORD_BITS-1:0]      result
);

   localparam int CNT_BITS = $clog2(COORD_BITS + 2);

   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS:0]   num_ff, num_in;
   logic [COORD_BITS-1:0] div_ff, div_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;

   assign trial  = {rem_ff, num_ff[COORD_BITS]};
   assign diff   = trial - {1'b0, div_ff};
   assign busy   = busy_ff || done_ff;
   assign done   = done_ff;
   // zero compare value reads as one
   assign result = (div_ff == '0) ? COORD_BITS'(1) : rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         num_in  = {1'b0, line} + (COORD_BITS + 1)'(1);
         div_in  = divisor;
         cnt_in  = CNT_BITS'(COORD_BITS + 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step: shift in one numerator bit, subtract if it fits
         rem_in = (trial >= {1'b0, div_ff}) ? diff[COORD_BITS-1:0]
                                            : trial[COORD_BITS-1:0];
         num_in = {num_ff[COORD_BITS-1:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/vsg_raster.sv @@
// Raster state of the video sync pulse generator: prescaler, x/y counters,
// line modulo counter and interrupt decode. Depends on vsg_pkg.
`default_nettype none

module vsg_raster
   import vsg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int OUT_BITS   = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  tick,
   input  wire cfg_type               cfg,
   input  wire logic                  mod_load,
   input  wire logic [COORD_BITS-1:0] mod_value,
   output logic [COORD_BITS-1:0]      line_now,
   output logic [OUT_BITS-1:0]        result
);

   localparam int CB = COORD_BITS;
   localparam int HL = HI_FIELD_LSB;

   logic [1:0]    presc_ff, presc_in;
   logic [CB-1:0] pix_ff, pix_in;
   logic [CB-1:0] line_ff, line_in;
   logic [CB-1:0] lmod_ff, lmod_in;

   logic [CB-1:0] cmp_line;
   hirq_mode_type mode;
   logic [1:0]    div_m1;
   logic          hirq, vin, vout, in_vblank, in_hblank;

   assign cmp_line = cfg.hblank_int[CB-1:0];
   assign mode     = hirq_mode_type'(cfg.hblank_int[MODE_LSB +: 2]);
   assign line_now = line_ff;

   // divide 1 or 2, doubled unless interlaced
   always_comb begin
      if (cfg.control[INTERLACE_BIT])
         div_m1 = {1'b0, cfg.pixel_div[1]};
      else
         div_m1 = cfg.pixel_div[1] ? 2'd3 : 2'd1;
   end

   always_comb begin
      presc_in = presc_ff;
      pix_in   = pix_ff;
      line_in  = line_ff;
      lmod_in  = lmod_ff;
      hirq     = 1'b0;
      vin      = 1'b0;
      vout     = 1'b0;
      if (advance && tick) begin
         if (presc_ff >= div_m1) begin
            presc_in = '0;
            if (pix_ff >= cfg.load[CB-1:0]) begin
               pix_in = '0;
               if (line_ff >= cfg.load[HL +: CB]) begin
                  line_in = '0;
                  lmod_in = (cmp_line == CB'(1)) ? '0 : CB'(1);
               end else begin
                  line_in = line_ff + CB'(1);
                  if (({1'b0, lmod_ff} + (CB + 1)'(1)) >= {1'b0, cmp_line})
                     lmod_in = '0;
                  else
                     lmod_in = lmod_ff + CB'(1);
               end
               case (mode)
                  HIRQ_ON_LINE: hirq = (cmp_line != '0) && (line_in == cmp_line);
                  HIRQ_MODULO:  hirq = (cmp_line != '0) && (lmod_in == '0);
                  HIRQ_EVERY:   hirq = 1'b1;
                  default:      hirq = 1'b0;
               endcase
               vin  = (line_in == cfg.vblank_int[CB-1:0]);
               vout = (line_in == cfg.vblank_int[HL +: CB]);
            end else begin
               pix_in = pix_ff + CB'(1);
            end
         end else begin
            presc_in = presc_ff + 2'd1;
         end
      end
      // a compare write realigns the modulo counter; no beat is taken then
      if (mod_load)
         lmod_in = mod_value;
   end

   assign in_vblank = (line_in < cfg.vblank[HL +: CB]) || (line_in >= cfg.vblank[CB-1:0]);
   assign in_hblank = (pix_in < cfg.hblank[HL +: CB]) || (pix_in >= cfg.hblank[CB-1:0]);

   assign result = OUT_BITS'({in_hblank, in_vblank, pix_in, line_in, vout, vin, hirq});

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff <= '0;
         pix_ff   <= '0;
         line_ff  <= '0;
         lmod_ff  <= CB'(1);
      end else begin
         presc_ff <= presc_in;
         pix_ff   <= pix_in;
         line_ff  <= line_in;
         lmod_ff  <= lmod_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/vsg_rsp_buf.sv @@
// Two-entry result buffer between the raster logic and the rsp_ channel.
// Depends on vsg_pkg only through the import convention.
`default_nettype none

module vsg_rsp_buf
   import vsg_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [WIDTH-1:0]      rsp_tdata
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = head_ff;
   assign full       = (count_ff == 2'd2);
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      case (count_ff)
         2'd0: if (push) head_in = push_data;
         2'd1: begin
            if (push && pop)
               head_in = push_data;
            else if (push)
               tail_in = push_data;
         end
         2'd2: if (pop) head_in = tail_ff;
         default: count_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         count_ff <= '0;
      else
         count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/video_sync_pulse_generator.sv @@
// Video sync pulse generator: raster counters with hblank/vblank interrupts.
// A result beat is registered in the two-entry result buffer before it is sent;
// one beat per cycle is taken while the buffer has room and the divider is idle.
// A write of the hblank interrupt word holds both channels while the serial
// remainder unit realigns the line modulo counter.
// Reset (synchronous, active high) clears the raster and loads register defaults.
`default_nettype none

module video_sync_pulse_generator
   import vsg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,  // [0] vclk_tick
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // hblank_irq, vblank_in_irq, vblank_out_irq, line_position,
   // pixel_position, in_vblank, in_hblank, then zero fill
   output logic [((2*COORD_BITS+5+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int OUT_BITS = ((2 * COORD_BITS + 5 + 7) / 8) * 8;

   cfg_type                cfg;
   logic                   mod_start, mod_busy, mod_done;
   logic [COORD_BITS-1:0]  mod_value;
   logic [COORD_BITS-1:0]  line_now;
   logic [OUT_BITS-1:0]    result;
   logic                   buf_full;
   logic                   accept;

   assign req_tready = !buf_full && !mod_busy;
   assign accept     = req_tvalid && req_tready;

   vsg_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mod_busy  (mod_busy),
      .mod_start (mod_start),
      .cfg       (cfg)
   );

   vsg_moddiv #(
      .COORD_BITS (COORD_BITS)
   ) u_moddiv (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .line    (line_now),
      .divisor (csr_data[COORD_BITS-1:0]),
      .busy    (mod_busy),
      .done    (mod_done),
      .result  (mod_value)
   );

   vsg_raster #(
      .COORD_BITS (COORD_BITS),
      .OUT_BITS   (OUT_BITS)
   ) u_raster (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .tick      (req_tdata[0]),
      .cfg       (cfg),
      .mod_load  (mod_done),
      .mod_value (mod_value),
      .line_now  (line_now),
      .result    (result)
   );

   vsg_rsp_buf #(
      .WIDTH (OUT_BITS)
   ) u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .full       (buf_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
